@@ rtl/pal_pkg.sv @@
// Shared types and codes for the positional array list unit.
package pal_pkg;

	localparam int POS_W  = 4;
	localparam int DATA_W = 32;

	localparam logic [2:0] FUNC_WRITE  = 3'd0;
	localparam logic [2:0] FUNC_INSERT = 3'd1;
	localparam logic [2:0] FUNC_DELETE = 3'd2;
	localparam logic [2:0] FUNC_SEARCH = 3'd3;
	localparam logic [2:0] FUNC_READ   = 3'd4;

	typedef struct packed {
		logic [2:0]              func;
		logic [POS_W-1:0]        position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
		logic                     error;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_DELETE
	} cell_kind_t;

	typedef struct packed {
		cell_kind_t               kind;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} key_t;

	typedef struct packed {
		logic                     vld;
		logic                     found;
		logic signed [DATA_W-1:0] rd;
	} scan_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

@@ rtl/pal_chan_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
interface pal_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input ready, input data);
endinterface

@@ rtl/pal_cell.sv @@
// One list entry: update from neighbors and pass the scan token on.
module pal_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pal_pkg::cell_cmd_t               cmd,
	input  pal_pkg::key_t                    key,
	input  logic signed [pal_pkg::DATA_W-1:0] left,
	input  logic signed [pal_pkg::DATA_W-1:0] right,
	input  pal_pkg::scan_t                   scan_in,
	output logic signed [pal_pkg::DATA_W-1:0] entry,
	output pal_pkg::scan_t                   scan_out
);
	import pal_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

	logic signed [DATA_W-1:0] entry_q;
	scan_t                    scan_q;
	logic [CW-1:0]            cmd_pos;
	logic [CW-1:0]            key_pos;
	logic                     at_pos;
	logic                     above_pos;
	logic                     key_hit;

	assign cmd_pos   = CW'(cmd.pos);
	assign key_pos   = CW'(key.pos);
	assign at_pos    = (cmd_pos == MY_IDX);
	assign above_pos = (MY_IDX > cmd_pos);
	assign key_hit   = (key_pos == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			case (cmd.kind)
				CELL_WRITE: begin
					if (at_pos) entry_q <= cmd.value;
				end
				CELL_INSERT: begin
					if (at_pos) entry_q <= cmd.value;
					else if (above_pos) entry_q <= left;
				end
				CELL_DELETE: begin
					if (at_pos || above_pos) entry_q <= right;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q.vld   <= scan_in.vld;
			scan_q.found <= scan_in.found | (entry_q == key.value);
			scan_q.rd    <= key_hit ? entry_q : scan_in.rd;
		end
	end

	assign entry    = entry_q;
	assign scan_out = scan_q;
endmodule

@@ rtl/positional_array_list_unit.sv @@
// Top level of the positional array list: control and the row of entry cells.
//
//   channel | dir | payload                         | accepted when
//   req     | in  | func, position, value           | req.valid && req.ready
//   rsp     | out | found, read_value, error        | rsp.valid && rsp.ready
//
// Write, insert, delete and any error item skip the scan; the result is
// registered at the edge that accepts the item.
// Search and in-range read go through a scan: a token walks the cell
// row, one cell per cycle, gathering the match flag and the addressed entry.
// Reset clears every entry to zero and empties the result register.
// A stalled result holds; a new item is taken only once the result register
// is free or is being drained in the same cycle.
module positional_array_list_unit #(
	parameter int DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	pal_chan_if.sink   req,
	pal_chan_if.source rsp
);
	import pal_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = ((IW > POS_W) ? IW : POS_W) + 1;

	state_t                   state_q;
	state_t                   state_d;
	logic                     start_q;
	logic                     search_q;
	key_t                     key_q;
	logic                     out_vld_q;
	rsp_t                     out_q;
	cell_cmd_t                cmd;
	logic signed [DATA_W-1:0] entry_w [DEPTH];
	scan_t                    scan_w  [DEPTH+1];
	logic                     accept;
	logic                     pos_ok;
	logic                     is_search;
	logic                     is_read;
	logic                     is_upd;
	logic                     needs_scan;
	logic                     item_err;

	assign accept     = req.valid && req.ready;
	assign pos_ok     = CW'(req.data.position) < CW'(DEPTH);
	assign is_search  = (req.data.func == FUNC_SEARCH);
	assign is_read    = (req.data.func == FUNC_READ);
	assign is_upd     = (req.data.func == FUNC_WRITE) || (req.data.func == FUNC_INSERT)
		|| (req.data.func == FUNC_DELETE);
	assign needs_scan = is_search || (is_read && pos_ok);
	assign item_err   = (is_upd || is_read) ? !pos_ok : !is_search;

	always_comb begin
		cmd.pos   = req.data.position;
		cmd.value = req.data.value;
		cmd.kind  = CELL_HOLD;
		if (accept && pos_ok) begin
			case (req.data.func)
				FUNC_WRITE:  cmd.kind = CELL_WRITE;
				FUNC_INSERT: cmd.kind = CELL_INSERT;
				FUNC_DELETE: cmd.kind = CELL_DELETE;
				default:     cmd.kind = CELL_HOLD;
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = !out_vld_q || rsp.ready;
				if (req.valid && req.ready && needs_scan) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_w[DEPTH].vld) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && needs_scan;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.pos   <= req.data.position;
			key_q.value <= req.data.value;
			search_q    <= is_search;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_SCAN && scan_w[DEPTH].vld) || (accept && !needs_scan)) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && scan_w[DEPTH].vld) begin
			out_q.found      <= search_q & scan_w[DEPTH].found;
			out_q.read_value <= search_q ? '0 : scan_w[DEPTH].rd;
			out_q.error      <= 1'b0;
		end else if (accept && !needs_scan) begin
			out_q.found      <= 1'b0;
			out_q.read_value <= '0;
			out_q.error      <= item_err;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign scan_w[0] = '{vld: start_q, found: 1'b0, rd: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		pal_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.key      (key_q),
			.left     (left_w),
			.right    (right_w),
			.scan_in  (scan_w[i]),
			.entry    (entry_w[i]),
			.scan_out (scan_w[i+1])
		);
	end
endmodule

@@ rtl/pal_chk.sv @@
// Port-level checks for the positional array list unit, bound to the top level.
module pal_chk (
	input logic        clk,
	input logic        arst_n,
	pal_chan_if.sink   req,
	pal_chan_if.source rsp
);
	import pal_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("stalled result changed or dropped");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !rsp.valid || rsp.ready)
		else $error("item taken while result slot is full");

	a_update_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.data.func == FUNC_WRITE
		|| req.data.func == FUNC_INSERT || req.data.func == FUNC_DELETE)
		|=> rsp.valid)
		else $error("update result not ready after one cycle");

	a_bad_func_error: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.data.func != FUNC_WRITE
		&& req.data.func != FUNC_INSERT && req.data.func != FUNC_DELETE
		&& req.data.func != FUNC_SEARCH && req.data.func != FUNC_READ
		|=> rsp.valid && rsp.data.error)
		else $error("invalid func did not flag error");

	a_search_waits: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.data.func == FUNC_SEARCH |=> !rsp.valid)
		else $error("search result appeared before the scan");
endmodule

bind positional_array_list_unit pal_chk u_pal_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
